// ===== sv/tlf_pkg.sv =====
// tlf_pkg: shared types and constants for the translation buffer
// used by tlf_ctrl, tlf_datapath, tlb_lookup_lru_fill_top and tlf_checker; no dependencies

package tlf_pkg;

  // request kinds carried on the slave-side tuser
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_FILL   = 1'b1;

  // fixed result field widths
  localparam int unsigned FOUND_W = 16;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned M_TDATA_W = ((FOUND_W + SLOT_W + 7) / 8) * 8;
  localparam int unsigned M_PAD_W   = M_TDATA_W - FOUND_W - SLOT_W;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture a new request
    logic search;  // compare tags, pick victim, read frame ram
    logic commit;  // update state and load the result register
  } tlf_cmd_t;

endpackage

// ===== sv/tlf_ctrl.sv =====
// tlf_ctrl: request sequencer and result-register valid for the translation buffer
// depends on tlf_pkg

module tlf_ctrl
  import tlf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_axis_tvalid_i,
  output logic     s_axis_tready_o,
  output logic     m_axis_tvalid_o,
  input  logic     m_axis_tready_i,
  output tlf_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       can_commit;
  logic       ready;

  // result register is free or drains this cycle
  assign can_commit = !out_valid_q || m_axis_tready_i;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    ready       = 1'b0;
    case (state_q)
      S_IDLE: begin
        ready = 1'b1;
      end
      S_SEARCH: begin
        cmd_o.search = 1'b1;
        state_d      = S_UPDATE;
      end
      S_UPDATE: begin
        if (can_commit) begin
          cmd_o.commit = 1'b1;
          ready        = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (ready && s_axis_tvalid_i) begin
      cmd_o.load = 1'b1;
      state_d    = S_SEARCH;
    end
  end

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_axis_tready_o = ready;
  assign m_axis_tvalid_o = out_valid_q;

endmodule

// ===== sv/tlf_datapath.sv =====
// tlf_datapath: tag store, frame ram, recency ranks and result register
// depends on tlf_pkg; driven by tlf_ctrl commands

module tlf_datapath
  import tlf_pkg::*;
#(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned PAGE_BITS  = 16,
  parameter int unsigned FRAME_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tlf_cmd_t              cmd_i,
  input  logic                  req_type_i,
  input  logic [PAGE_BITS-1:0]  vpn_i,
  input  logic [FRAME_BITS-1:0] pfn_i,
  output logic                  hit_o,
  output logic [FOUND_W-1:0]    found_frame_o,
  output logic [SLOT_W-1:0]     slot_index_o
);

  localparam int unsigned IDX_W  = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LRU_RANK = IDX_W'(ENTRIES - 1);

  // request registers
  logic                  req_type_q;
  logic [PAGE_BITS-1:0]  req_page_q;
  logic [FRAME_BITS-1:0] req_frame_q;

  // entry state
  logic [ENTRIES-1:0]    valid_q;
  logic [PAGE_BITS-1:0]  page_q [ENTRIES];
  logic [IDX_W-1:0]      rank_q [ENTRIES];
  logic [FRAME_BITS-1:0] frame_mem [ENTRIES];

  // search results
  logic                  hit_d, hit_q;
  logic [IDX_W-1:0]      hit_idx_d, hit_idx_q;
  logic [IDX_W-1:0]      victim_d, victim_q;
  logic [FRAME_BITS-1:0] rd_frame_q;

  // update signals
  logic                  is_fill;
  logic                  do_touch;
  logic [IDX_W-1:0]      touch_idx;
  logic [IDX_W-1:0]      old_rank;

  // result register
  logic                  res_hit_q;
  logic [FOUND_W-1:0]    res_frame_q;
  logic [SLOT_W-1:0]     res_slot_q;

  // capture request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_type_q  <= req_type_i;
      req_page_q  <= vpn_i;
      req_frame_q <= pfn_i;
    end
  end

  // parallel tag compare, lowest matching index wins
  always_comb begin
    hit_d     = 1'b0;
    hit_idx_d = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && (page_q[i] == req_page_q)) begin
        hit_d     = 1'b1;
        hit_idx_d = IDX_W'(i);
      end
    end
  end

  // victim: lowest invalid entry, else the least recent one
  always_comb begin
    logic [IDX_W-1:0] lru_idx;
    logic             any_free;
    logic [IDX_W-1:0] free_idx;
    lru_idx  = '0;
    any_free = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (rank_q[i] == LRU_RANK) begin
        lru_idx = IDX_W'(i);
      end
      if (!valid_q[i]) begin
        any_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
    victim_d = any_free ? free_idx : lru_idx;
  end

  // search stage registers and frame ram read
  always_ff @(posedge clk_i) begin
    if (cmd_i.search) begin
      hit_q      <= hit_d;
      hit_idx_q  <= hit_idx_d;
      victim_q   <= victim_d;
      rd_frame_q <= frame_mem[hit_idx_d];
    end
    if (cmd_i.commit && is_fill) begin
      frame_mem[victim_q] <= req_frame_q;
    end
  end

  assign is_fill   = (req_type_q == REQ_FILL);
  assign do_touch  = cmd_i.commit && (is_fill || hit_q);
  assign touch_idx = is_fill ? victim_q : hit_idx_q;
  assign old_rank  = rank_q[touch_idx];

  // valid bits and recency ranks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= IDX_W'(i);
      end
    end else begin
      if (cmd_i.commit && is_fill) begin
        valid_q[victim_q] <= 1'b1;
      end
      if (do_touch) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (IDX_W'(i) == touch_idx) begin
            rank_q[i] <= '0;
          end else if (rank_q[i] < old_rank) begin
            rank_q[i] <= rank_q[i] + 1'b1;
          end
        end
      end
    end
  end

  // tag write on fill
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && is_fill) begin
      page_q[victim_q] <= req_page_q;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (is_fill) begin
        res_hit_q   <= 1'b1;
        res_frame_q <= FOUND_W'(req_frame_q);
        res_slot_q  <= SLOT_W'(victim_q);
      end else if (hit_q) begin
        res_hit_q   <= 1'b1;
        res_frame_q <= FOUND_W'(rd_frame_q);
        res_slot_q  <= SLOT_W'(hit_idx_q);
      end else begin
        res_hit_q   <= 1'b0;
        res_frame_q <= '0;
        res_slot_q  <= '0;
      end
    end
  end

  assign hit_o         = res_hit_q;
  assign found_frame_o = res_frame_q;
  assign slot_index_o  = res_slot_q;

endmodule

// ===== sv/tlb_lookup_lru_fill_top.sv =====
// Fully associative translation buffer with exact LRU replacement. Each request
// passes through a search state that compares the page against every tag in
// parallel, picks the fill victim and reads the frame ram, then an update state
// that updates the recency ranks, writes the entry and loads the result register.
// The next request enters in the cycle its predecessor's result is loaded, so a
// new request is taken while the previous one is in its update state but not
// during its search; a stalled result holds the update state. Duplicate pages are
// not checked on fill; a lookup returns the lowest matching entry.
//
// top level: stream ports, field packing; depends on tlf_pkg, tlf_ctrl,
// tlf_datapath

module tlb_lookup_lru_fill_top
  import tlf_pkg::*;
#(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned PAGE_BITS  = 16,
  parameter int unsigned FRAME_BITS = 16,
  localparam int unsigned S_TDATA_W = ((PAGE_BITS + FRAME_BITS + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // low to high: virtual page, physical frame, zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // req_type
  input  logic                 s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // low to high: found_frame, slot_index, zero pad
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  // hit
  output logic                 m_axis_tuser_o
);

  tlf_cmd_t           cmd;
  logic [FOUND_W-1:0] found_frame;
  logic [SLOT_W-1:0]  slot_index;

  tlf_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cmd_o           (cmd)
  );

  tlf_datapath #(
    .ENTRIES    (ENTRIES),
    .PAGE_BITS  (PAGE_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .req_type_i     (s_axis_tuser_i),
    .vpn_i          (s_axis_tdata_i[PAGE_BITS-1:0]),
    .pfn_i          (s_axis_tdata_i[PAGE_BITS +: FRAME_BITS]),
    .hit_o          (m_axis_tuser_o),
    .found_frame_o  (found_frame),
    .slot_index_o   (slot_index)
  );

  // result packing
  assign m_axis_tdata_o = {{M_PAD_W{1'b0}}, slot_index, found_frame};

endmodule

// ===== sv/tlf_checker.sv =====
// tlf_checker: port-level assertions for tlb_lookup_lru_fill_top, bound below
// depends on tlf_pkg

module tlf_checker
  import tlf_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_o,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [M_TDATA_W-1:0] m_axis_tdata_o,
  input logic                 m_axis_tuser_o
);

  logic s_xfer;
  assign s_xfer = s_axis_tvalid_i && s_axis_tready_o;

  // a held result stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // a held result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result payload changed while stalled");

  // a request is busy for its search cycle
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> !s_axis_tready_o)
    else $error("request taken during search cycle");

  // a miss reports zero frame and slot
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("miss carries nonzero frame or slot");

endmodule

bind tlb_lookup_lru_fill_top tlf_checker u_tlf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
